// ===== rtl/sgdq_pkg.sv =====
package sgdq_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIELD_TIME_GAIN = 3'd0,
        CFG_FIELD_RES       = 3'd1,
        CFG_INV_FIELD_IND   = 3'd2,
        CFG_D_MUTUAL_IND    = 3'd3,
        CFG_D_TOTAL_IND     = 3'd4,
        CFG_Q_TOTAL_IND     = 3'd5,
        CFG_SPEED_GAIN      = 3'd6,
        CFG_CURRENT_SCALE   = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        SH_FRAC,
        SH_Q30
    } t_shift;

    typedef struct packed {
        t_shift shift;
        logic   sat_en;
    } t_mul_mode;

    localparam logic signed [33:0] Q30_ONE        = 34'sd1073741824;
    localparam logic signed [33:0] TWO_THIRDS_Q30 = 34'sd715827883;
    localparam logic signed [33:0] TURN_PER_RAD   = 34'sd683565276;
    localparam logic signed [33:0] SINE_C9        = 34'sd172272;
    localparam logic [31:0]        THIRD_TURN     = 32'd1431655765;

    function automatic logic signed [33:0] sine_coef(input logic [3:0] k);
        logic signed [33:0] c;
        case (k)
            4'd1:    c = -34'sd5026995;
            4'd2:    c = 34'sd85569306;
            4'd3:    c = -34'sd693598668;
            4'd4:    c = 34'sd1686629713;
            default: c = 34'sd0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/sgdq_in_if.sv =====
interface sgdq_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] phase_a_current;
    logic signed [DATA_WIDTH-1:0] phase_b_current;
    logic signed [DATA_WIDTH-1:0] phase_c_current;
    logic signed [DATA_WIDTH-1:0] mechanical_torque;
    logic signed [DATA_WIDTH-1:0] field_voltage;

    modport source (
        output valid, phase_a_current, phase_b_current, phase_c_current,
               mechanical_torque, field_voltage,
        input  ready
    );
    modport sink (
        input  valid, phase_a_current, phase_b_current, phase_c_current,
               mechanical_torque, field_voltage,
        output ready
    );
endinterface

// ===== rtl/sgdq_out_if.sv =====
interface sgdq_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] phase_a_voltage;
    logic signed [DATA_WIDTH-1:0] phase_b_voltage;
    logic signed [DATA_WIDTH-1:0] phase_c_voltage;
    logic signed [DATA_WIDTH-1:0] electrical_torque;
    logic signed [DATA_WIDTH-1:0] rotor_speed;
    logic [31:0]                  rotor_position;

    modport source (
        output valid, phase_a_voltage, phase_b_voltage, phase_c_voltage,
               electrical_torque, rotor_speed, rotor_position,
        input  ready
    );
    modport sink (
        input  valid, phase_a_voltage, phase_b_voltage, phase_c_voltage,
               electrical_torque, rotor_speed, rotor_position,
        output ready
    );
endinterface

// ===== rtl/sgdq_mul.sv =====
module sgdq_mul
    import sgdq_pkg::*;
#(
    parameter int IW = 34,
    parameter int DW = 32,
    parameter int FW = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [IW-1:0] i_a,
    input  logic signed [IW-1:0] i_b,
    input  t_mul_mode            i_mode,
    output logic                 o_done,
    output logic signed [IW-1:0] o_res
);

    localparam int ND = (IW + 15) / 16;
    localparam int BW = ND * 16;
    localparam int PW = IW + BW;
    localparam int CW = $clog2(ND + 1);
    localparam logic [PW:0] RND_F   = (PW + 1)'(1) << (FW - 1);
    localparam logic [PW:0] RND_Q30 = (PW + 1)'(1) << 29;
    localparam logic signed [IW-1:0] DMAX = IW'({1'b0, {(DW - 1){1'b1}}});
    localparam logic signed [IW-1:0] DMIN = ~DMAX;

    logic                 r_busy;
    logic                 r_done;
    logic                 r_neg;
    logic [IW-1:0]        r_ma;
    logic [BW-1:0]        r_mb;
    logic [PW-1:0]        r_prod;
    logic [CW-1:0]        r_cnt;
    t_mul_mode            r_mode;
    logic signed [IW-1:0] r_res;

    logic [IW+15:0]       part;
    logic [PW:0]          q;
    logic [IW-1:0]        qi;
    logic                 hi_nz;
    logic                 neg_ovf;
    logic signed [IW-1:0] res;

    function automatic logic [IW-1:0] mag(input logic signed [IW-1:0] x);
        return x[IW-1] ? IW'(-x) : IW'(x);
    endfunction

    assign part = {16'b0, r_ma} * {{IW{1'b0}}, r_mb[BW-1 -: 16]};

    always_comb begin
        if (r_mode.shift == SH_Q30) begin
            q = ({1'b0, r_prod} + RND_Q30) >> 30;
        end else begin
            q = ({1'b0, r_prod} + RND_F) >> FW;
        end
        qi      = q[IW-1:0];
        hi_nz   = |q[PW:DW-1];
        neg_ovf = hi_nz && !(q[PW:DW-1] == (PW - DW + 2)'(1) && q[DW-2:0] == '0);
        if (r_mode.sat_en && (r_neg ? neg_ovf : hi_nz)) begin
            res = r_neg ? DMIN : DMAX;
        end else begin
            res = r_neg ? signed'(IW'(-qi)) : signed'(qi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_neg  <= i_a[IW-1] ^ i_b[IW-1];
                r_ma   <= mag(i_a);
                r_mb   <= BW'(mag(i_b));
                r_prod <= '0;
                r_cnt  <= CW'(ND);
                r_mode <= i_mode;
            end else if (r_busy && r_cnt != '0) begin
                r_prod <= (r_prod << 16) + PW'(part);
                r_mb   <= r_mb << 16;
                r_cnt  <= r_cnt - 1'b1;
            end else if (r_busy) begin
                r_res  <= res;
                r_done <= 1'b1;
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/synchronous_generator_dq_step_unit.sv =====
// Channel    Dir  Word
// i_step     in   three phase currents, mechanical torque, field voltage
// o_step     out  three phase voltages, electrical torque, speed, position
// i_cfg_*    in   register write: enable, index, data
//
// One step takes 101 products on a digit-serial multiplier of (IW+15)/16 digits of
// 16 bits, with IW = max(DATA_WIDTH + 2, 34).
// This one multiplier forms every product of the step.
// A new word is taken only when the sequencer is idle; a finished word waits in
// the output register and the next step may run meanwhile.
// Reset is synchronous and needs no clearing pass.
module synchronous_generator_dq_step_unit
    import sgdq_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_WIDTH-1:0] i_cfg_data,
    sgdq_in_if.sink               i_step,
    sgdq_out_if.source            o_step
);

    localparam int IW = (DATA_WIDTH + 2 > 34) ? DATA_WIDTH + 2 : 34;
    localparam int DW = DATA_WIDTH;

    typedef logic signed [IW-1:0] t_word;
    typedef logic signed [DW-1:0] t_data;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PH,
        S_QS,
        S_USE,
        S_MID,
        S_DONE
    } t_state;

    localparam t_word DMAX_W = t_word'({1'b0, {(DW - 1){1'b1}}});
    localparam t_word DMIN_W = ~DMAX_W;
    localparam t_word ONE_W  = t_word'(Q30_ONE);
    localparam t_data ONE_PU = t_data'(1) <<< FRAC_BITS;

    t_state      r_state;
    logic        r_wait;
    logic [1:0]  r_j;
    logic [3:0]  r_k;
    logic        r_h;
    logic        r_pass;

    t_data r_ftg, r_fres, r_ifl, r_dm, r_dt, r_qt, r_sg, r_cscale;
    t_data r_icur [3];
    t_data r_tm, r_vf;

    t_word r_ph [3];
    t_word r_va [3];
    t_word r_sum_c, r_sum_s, r_id, r_iq, r_u, r_ff, r_fc, r_t1;
    t_word r_psid, r_psiq, r_vd, r_te, r_spd, r_v2, r_acc, r_sr, r_sc;
    logic [31:0] r_ang;

    logic        r_out_valid;
    t_data       r_o_pa, r_o_pb, r_o_pc, r_o_te, r_o_spd;
    logic [31:0] r_o_pos;

    logic        mul_start;
    logic        mul_done;
    t_word       mul_a, mul_b, mres;
    t_mul_mode   mul_mode;
    logic [31:0] ang_j;
    t_word       frac, v, sn, cs, clamp;

    function automatic t_word ext(input t_data x);
        return t_word'(x);
    endfunction

    function automatic t_word sat(input t_word x);
        if (x > DMAX_W) return DMAX_W;
        if (x < DMIN_W) return DMIN_W;
        return x;
    endfunction

    always_comb begin
        case (r_j)
            2'd1:    ang_j = r_ang - THIRD_TURN;
            2'd2:    ang_j = r_ang + THIRD_TURN;
            default: ang_j = r_ang;
        endcase
        frac = t_word'({1'b0, ang_j[29:0]});
        v    = r_h ? ONE_W - frac : frac;
        case (ang_j[31:30])
            2'd0:    begin sn = r_sr;  cs = r_sc;  end
            2'd1:    begin sn = r_sc;  cs = -r_sr; end
            2'd2:    begin sn = -r_sr; cs = -r_sc; end
            default: begin sn = -r_sc; cs = r_sr;  end
        endcase
        if (mres < 0) begin
            clamp = '0;
        end else if (mres > ONE_W) begin
            clamp = ONE_W;
        end else begin
            clamp = mres;
        end
    end

    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        mul_mode = '{shift: SH_FRAC, sat_en: 1'b1};
        unique case (r_state)
            S_PH: begin
                mul_a = ext(r_icur[r_j]);
                mul_b = ext(r_cscale);
            end
            S_QS: begin
                mul_mode = '{shift: SH_Q30, sat_en: 1'b0};
                case (r_k) inside
                    4'd0:                 begin mul_a = v;               mul_b = v;    end
                    4'd1:                 begin mul_a = t_word'(SINE_C9); mul_b = r_v2; end
                    [4'd2:4'd4]:          begin mul_a = r_acc;           mul_b = r_v2; end
                    default:              begin mul_a = r_acc;           mul_b = v;    end
                endcase
            end
            S_USE: begin
                mul_mode = '{shift: SH_Q30, sat_en: 1'b1};
                mul_a    = r_k[0] ? sn : cs;
                if (r_pass) begin
                    mul_b = r_k[0] ? r_psid : r_vd;
                end else begin
                    mul_b = r_ph[r_j];
                end
            end
            S_MID: begin
                case (r_k)
                    4'd0: begin
                        mul_a    = r_sum_c;
                        mul_b    = t_word'(TWO_THIRDS_Q30);
                        mul_mode = '{shift: SH_Q30, sat_en: 1'b1};
                    end
                    4'd1: begin
                        mul_a    = r_sum_s;
                        mul_b    = t_word'(TWO_THIRDS_Q30);
                        mul_mode = '{shift: SH_Q30, sat_en: 1'b1};
                    end
                    4'd2:  begin mul_a = ext(r_fres); mul_b = r_fc;        end
                    4'd3:  begin mul_a = ext(r_ftg);  mul_b = r_u;         end
                    4'd4:  begin mul_a = ext(r_dm);   mul_b = r_id;        end
                    4'd5:  begin mul_a = r_u;         mul_b = ext(r_ifl);  end
                    4'd6:  begin mul_a = ext(r_dm);   mul_b = r_fc;        end
                    4'd7:  begin mul_a = ext(r_dt);   mul_b = r_id;        end
                    4'd8:  begin mul_a = ext(r_qt);   mul_b = r_iq;        end
                    4'd9:  begin mul_a = r_psid;      mul_b = r_iq;        end
                    4'd10: begin mul_a = r_psiq;      mul_b = r_id;        end
                    4'd11: begin mul_a = ext(r_sg);   mul_b = sat(ext(r_tm) - r_te); end
                    4'd12: begin mul_a = ext(r_ftg);  mul_b = r_spd;       end
                    default: begin
                        mul_a    = r_t1;
                        mul_b    = t_word'(TURN_PER_RAD);
                        mul_mode = '{shift: SH_FRAC, sat_en: 1'b0};
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign mul_start = !r_wait && (r_state == S_PH || r_state == S_QS ||
                                   r_state == S_USE || r_state == S_MID);

    sgdq_mul #(
        .IW (IW),
        .DW (DW),
        .FW (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_mode  (mul_mode),
        .o_done  (mul_done),
        .o_res   (mres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
            r_j         <= '0;
            r_k         <= '0;
            r_h         <= 1'b0;
            r_pass      <= 1'b0;
            r_ftg       <= '0;
            r_fres      <= '0;
            r_ifl       <= '0;
            r_dm        <= '0;
            r_dt        <= '0;
            r_qt        <= '0;
            r_sg        <= '0;
            r_cscale    <= ONE_PU;
            r_ff        <= '0;
            r_fc        <= '0;
            r_spd       <= ext(ONE_PU);
            r_ang       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_FIELD_TIME_GAIN: r_ftg    <= i_cfg_data;
                    CFG_FIELD_RES:       r_fres   <= i_cfg_data;
                    CFG_INV_FIELD_IND:   r_ifl    <= i_cfg_data;
                    CFG_D_MUTUAL_IND:    r_dm     <= i_cfg_data;
                    CFG_D_TOTAL_IND:     r_dt     <= i_cfg_data;
                    CFG_Q_TOTAL_IND:     r_qt     <= i_cfg_data;
                    CFG_SPEED_GAIN:      r_sg     <= i_cfg_data;
                    CFG_CURRENT_SCALE:   r_cscale <= i_cfg_data;
                endcase
            end

            if (o_step.valid && o_step.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            if (mul_start) begin
                r_wait <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_step.valid) begin
                        r_icur[0] <= i_step.phase_a_current;
                        r_icur[1] <= i_step.phase_b_current;
                        r_icur[2] <= i_step.phase_c_current;
                        r_tm      <= i_step.mechanical_torque;
                        r_vf      <= i_step.field_voltage;
                        r_sum_c   <= '0;
                        r_sum_s   <= '0;
                        r_j       <= '0;
                        r_state   <= S_PH;
                    end
                end
                S_PH: begin
                    if (r_wait && mul_done) begin
                        r_wait     <= 1'b0;
                        r_ph[r_j]  <= mres;
                        if (r_j == 2'd2) begin
                            r_j     <= '0;
                            r_h     <= 1'b0;
                            r_k     <= '0;
                            r_pass  <= 1'b0;
                            r_state <= S_QS;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                S_QS: begin
                    if (r_wait && mul_done) begin
                        r_wait <= 1'b0;
                        if (r_k == 4'd0) begin
                            r_v2 <= mres;
                            r_k  <= r_k + 1'b1;
                        end else if (r_k != 4'd5) begin
                            r_acc <= mres + t_word'(sine_coef(r_k));
                            r_k   <= r_k + 1'b1;
                        end else begin
                            r_k <= '0;
                            if (!r_h) begin
                                r_sr <= clamp;
                                r_h  <= 1'b1;
                            end else begin
                                r_sc    <= clamp;
                                r_state <= S_USE;
                            end
                        end
                    end
                end
                S_USE: begin
                    if (r_wait && mul_done) begin
                        r_wait <= 1'b0;
                        if (!r_k[0]) begin
                            if (r_pass) begin
                                r_t1 <= mres;
                            end else begin
                                r_sum_c <= r_sum_c + mres;
                            end
                            r_k <= 4'd1;
                        end else begin
                            if (r_pass) begin
                                r_va[r_j] <= sat(r_t1 - mres);
                            end else begin
                                r_sum_s <= r_sum_s + mres;
                            end
                            r_k <= '0;
                            r_h <= 1'b0;
                            if (r_j != 2'd2) begin
                                r_j     <= r_j + 1'b1;
                                r_state <= S_QS;
                            end else if (r_pass) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_MID;
                            end
                        end
                    end
                end
                S_MID: begin
                    if (r_wait && mul_done) begin
                        r_wait <= 1'b0;
                        r_k    <= (r_k == 4'd13) ? 4'd0 : r_k + 1'b1;
                        case (r_k)
                            4'd0:  r_id  <= mres;
                            4'd1:  r_iq  <= sat(-mres);
                            4'd2:  r_u   <= sat(ext(r_vf) - mres);
                            4'd3:  r_ff  <= sat(r_ff + mres);
                            4'd4:  r_u   <= sat(r_ff + mres);
                            4'd5:  r_fc  <= mres;
                            4'd6:  r_t1  <= mres;
                            4'd7:  r_psid <= sat(r_t1 - mres);
                            4'd8: begin
                                r_psiq <= sat(-mres);
                                r_vd   <= sat(-sat(-mres));
                            end
                            4'd9:  r_t1  <= mres;
                            4'd10: r_te  <= sat(r_t1 - mres);
                            4'd11: r_spd <= sat(r_spd + mres);
                            4'd12: r_t1  <= mres;
                            default: begin
                                r_ang   <= r_ang + mres[31:0];
                                r_j     <= '0;
                                r_h     <= 1'b0;
                                r_pass  <= 1'b1;
                                r_state <= S_QS;
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_step.ready) begin
                        r_o_pa      <= r_va[0][DW-1:0];
                        r_o_pb      <= r_va[1][DW-1:0];
                        r_o_pc      <= r_va[2][DW-1:0];
                        r_o_te      <= r_te[DW-1:0];
                        r_o_spd     <= r_spd[DW-1:0];
                        r_o_pos     <= r_ang;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_step.ready             = (r_state == S_IDLE);
    assign o_step.valid             = r_out_valid;
    assign o_step.phase_a_voltage   = r_o_pa;
    assign o_step.phase_b_voltage   = r_o_pb;
    assign o_step.phase_c_voltage   = r_o_pc;
    assign o_step.electrical_torque = r_o_te;
    assign o_step.rotor_speed       = r_o_spd;
    assign o_step.rotor_position    = r_o_pos;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step.valid && i_step.ready) |=> (r_state == S_PH))
        else $error("accepted word did not start the sequence");

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> r_wait)
        else $error("multiplier finished with no product pending");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_step.valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the completion state");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import sgdq_pkg::*;

    localparam int  DW        = 32;
    localparam int  FB        = 24;
    localparam int  LATENCY   = 700;
    localparam int  WD_LIMIT  = 20000;
    localparam int  HOLD_LEN  = 3000;
    localparam longint DMAX   = 64'sd2147483647;
    localparam longint DMIN   = -64'sd2147483648;
    localparam longint Q30    = 64'sd1073741824;

    typedef struct {
        logic [DW-1:0] ia, ib, ic, tm, vf;
    } t_step_word;

    typedef struct {
        logic [DW-1:0] va, vb, vc, te, spd;
        logic [31:0]   pos;
    } t_volt_word;

    class sgdq_scoreboard;
        longint        gain_t, res_f, inv_lf, ld_m, ld_t, lq_t, gain_w, scale_i;
        longint        flux_f, cur_f, speed;
        logic [31:0]   angle;
        t_volt_word    expected_q[$];
        int            errors;

        function new();
            gain_t = 0; res_f = 0; inv_lf = 0; ld_m = 0; ld_t = 0; lq_t = 0;
            gain_w = 0; scale_i = 64'sd1 << FB;
            flux_f = 0; cur_f = 0; speed = 64'sd1 << FB; angle = 0; errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [DW-1:0] data);
            longint v;
            v = longint'($signed(data));
            case (idx)
                CFG_FIELD_TIME_GAIN: gain_t  = v;
                CFG_FIELD_RES:       res_f   = v;
                CFG_INV_FIELD_IND:   inv_lf  = v;
                CFG_D_MUTUAL_IND:    ld_m    = v;
                CFG_D_TOTAL_IND:     ld_t    = v;
                CFG_Q_TOTAL_IND:     lq_t    = v;
                CFG_SPEED_GAIN:      gain_w  = v;
                default:             scale_i = v;
            endcase
        endfunction

        function longint clip(longint v);
            if (v > DMAX) return DMAX;
            if (v < DMIN) return DMIN;
            return v;
        endfunction

        function logic [127:0] rounded_mag(longint a, longint b, int sh);
            logic [63:0] ma, mb;
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            return ({64'd0, ma} * {64'd0, mb} + (128'd1 << (sh - 1))) >> sh;
        endfunction

        function longint mul_clip(longint a, longint b, int sh);
            logic [127:0] p;
            p = rounded_mag(a, b, sh);
            if ((a < 0) != (b < 0)) begin
                if (p > 128'h8000_0000) return DMIN;
                return -longint'(p[63:0]);
            end
            if (p > 128'h7fff_ffff) return DMAX;
            return longint'(p[63:0]);
        endfunction

        function logic [31:0] mul_wrap(longint a, longint b, int sh);
            logic [127:0] p;
            p = rounded_mag(a, b, sh);
            if ((a < 0) != (b < 0)) return -p[31:0];
            return p[31:0];
        endfunction

        function longint mul_q30(longint a, longint b);
            longint unsigned p, ma, mb;
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            p = (ma * mb + (64'd1 << 29)) >> 30;
            return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
        endfunction

        function longint quarter_sine(longint v);
            longint v2, acc;
            v2 = mul_q30(v, v);
            acc = 172272;
            acc = mul_q30(acc, v2) - 5026995;
            acc = mul_q30(acc, v2) + 85569306;
            acc = mul_q30(acc, v2) - 693598668;
            acc = mul_q30(acc, v2) + 1686629713;
            acc = mul_q30(acc, v);
            if (acc < 0) acc = 0;
            if (acc > Q30) acc = Q30;
            return acc;
        endfunction

        function void sin_cos(logic [31:0] t, output longint s, output longint c);
            longint r, sr, sc;
            r = longint'({34'd0, t[29:0]});
            sr = quarter_sine(r);
            sc = quarter_sine(Q30 - r);
            case (t[31:30])
                2'd0: begin s = sr;  c = sc;  end
                2'd1: begin s = sc;  c = -sr; end
                2'd2: begin s = -sr; c = -sc; end
                default: begin s = -sc; c = sr; end
            endcase
        endfunction

        function void note_step(t_step_word w);
            longint ph[3], sn, cs, sum_c, sum_s, id, iq, psid, psiq, vd, vq, te, rad;
            logic [31:0] ang[3];
            logic [DW-1:0] va[3];
            t_volt_word r;
            ph[0] = mul_clip(longint'($signed(w.ia)), scale_i, FB);
            ph[1] = mul_clip(longint'($signed(w.ib)), scale_i, FB);
            ph[2] = mul_clip(longint'($signed(w.ic)), scale_i, FB);
            ang[0] = angle; ang[1] = angle - THIRD_TURN; ang[2] = angle + THIRD_TURN;
            sum_c = 0; sum_s = 0;
            for (int i = 0; i < 3; i++) begin
                sin_cos(ang[i], sn, cs);
                sum_c += mul_clip(cs, ph[i], 30);
                sum_s += mul_clip(sn, ph[i], 30);
            end
            id = mul_clip(sum_c, TWO_THIRDS_Q30, 30);
            iq = clip(-mul_clip(sum_s, TWO_THIRDS_Q30, 30));
            flux_f = clip(flux_f + mul_clip(gain_t,
                clip(longint'($signed(w.vf)) - mul_clip(res_f, cur_f, FB)), FB));
            cur_f = mul_clip(clip(flux_f + mul_clip(ld_m, id, FB)), inv_lf, FB);
            psid = clip(mul_clip(ld_m, cur_f, FB) - mul_clip(ld_t, id, FB));
            psiq = clip(-mul_clip(lq_t, iq, FB));
            vd = clip(-psiq);
            vq = psid;
            te = clip(mul_clip(psid, iq, FB) - mul_clip(psiq, id, FB));
            speed = clip(speed + mul_clip(gain_w, clip(longint'($signed(w.tm)) - te), FB));
            rad = mul_clip(gain_t, speed, FB);
            angle = angle + mul_wrap(rad, TURN_PER_RAD, FB);
            ang[0] = angle; ang[1] = angle - THIRD_TURN; ang[2] = angle + THIRD_TURN;
            for (int i = 0; i < 3; i++) begin
                sin_cos(ang[i], sn, cs);
                va[i] = DW'(clip(mul_clip(cs, vd, 30) - mul_clip(sn, vq, 30)));
            end
            r.va = va[0]; r.vb = va[1]; r.vc = va[2];
            r.te = DW'(te); r.spd = DW'(speed); r.pos = angle;
            expected_q.push_back(r);
        endfunction

        function void check_field(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                $error("%s expected %0h actual %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_volts(t_volt_word a);
            t_volt_word e;
            if (expected_q.size() == 0) begin
                $error("word without expectation: torque %0h", a.te);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            check_field("phase_a_voltage", e.va, a.va);
            check_field("phase_b_voltage", e.vb, a.vb);
            check_field("phase_c_voltage", e.vc, a.vc);
            check_field("electrical_torque", e.te, a.te);
            check_field("rotor_speed", e.spd, a.spd);
            check_field("rotor_position", e.pos, a.pos);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DW-1:0]        i_cfg_data;

    sgdq_in_if  #(.DATA_WIDTH(DW)) step_in ();
    sgdq_out_if #(.DATA_WIDTH(DW)) step_out ();

    synchronous_generator_dq_step_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (step_in.sink),
        .o_step     (step_out.source)
    );

    sgdq_scoreboard gen_model;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             hold_req;
    int             hold_cnt;
    int             quiet_cycles;

    initial begin
        i_clk = 1'b0;
        gen_model = new();
    end
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_volt_word got;
        if (!i_rst_n) begin
            step_out.ready <= 1'b0;
            quiet_cycles   <= 0;
            hold_cnt       <= 0;
        end else begin
            if (step_out.valid && step_out.ready) begin
                got.va = step_out.phase_a_voltage;
                got.vb = step_out.phase_b_voltage;
                got.vc = step_out.phase_c_voltage;
                got.te = step_out.electrical_torque;
                got.spd = step_out.rotor_speed;
                got.pos = step_out.rotor_position;
                gen_model.check_volts(got);
            end
            if ((step_out.valid && step_out.ready) || (step_in.valid && step_in.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WD_LIMIT) begin
                $display("status: fail");
                $finish;
            end else
                quiet_cycles <= quiet_cycles + 1;
            if (hold_req > 0) begin
                hold_cnt <= hold_req;
                hold_req = 0;
                step_out.ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                step_out.ready <= 1'b0;
            end else
                step_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_regs(input logic [DW-1:0] vals[8]);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= vals[i];
            gen_model.set_reg(t_cfg_idx'(i), vals[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (gen_model.expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic send_step(input t_step_word w);
        if ($urandom_range(99) < send_idle_pct) begin
            step_in.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        step_in.valid             <= 1'b1;
        step_in.phase_a_current   <= w.ia;
        step_in.phase_b_current   <= w.ib;
        step_in.phase_c_current   <= w.ic;
        step_in.mechanical_torque <= w.tm;
        step_in.field_voltage     <= w.vf;
        do @(posedge i_clk); while (!step_in.ready);
        gen_model.note_step(w);
    endtask

    task automatic stop_sending();
        step_in.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [DW-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom();
            3: return 32'd0;
            default: return DW'($signed($urandom_range(33554432)) - 32'sd16777216);
        endcase
    endfunction

    function automatic t_step_word random_step();
        t_step_word w;
        w.ia = pick_value(); w.ib = pick_value(); w.ic = pick_value();
        w.tm = pick_value(); w.vf = pick_value();
        return w;
    endfunction

    logic [DW-1:0] cfg_vals[8];
    t_step_word    w;

    initial begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        step_in.valid = 1'b0;
        step_in.phase_a_current = '0;
        step_in.phase_b_current = '0;
        step_in.phase_c_current = '0;
        step_in.mechanical_torque = '0;
        step_in.field_voltage = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A few steps at reset settings, then a plausible machine.
        for (int i = 0; i < 4; i++) send_step(random_step());
        stop_sending();
        wait_drained();
        cfg_vals = '{32'd335544, 32'd16777, 32'd9320675, 32'd28521267,
                     32'd30198989, 32'd28521267, 32'd167772, 32'd16777216};
        write_regs(cfg_vals);
        for (int i = 0; i < 20; i++) begin
            case (i % 5)
                0: w = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h8000_0000};
                1: w = '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                         32'h7fff_ffff};
                2: w = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
                3: w = '{32'hffff_ffff, 32'h0000_0001, 32'h0, 32'h0100_0000, 32'h0100_0000};
                default: w = random_step();
            endcase
            send_step(w);
        end
        stop_sending();

        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            for (int k = 0; k < 8; k++) begin
                case (ph)
                    0, 4: cfg_vals[k] = DW'($signed($urandom_range(67108864)) - 32'sd33554432);
                    1: cfg_vals[k] = 32'h7fff_ffff;
                    2: cfg_vals[k] = 32'h8000_0000;
                    3: cfg_vals[k] = $urandom();
                    5: cfg_vals[k] = '0;
                    default: cfg_vals[k] = DW'($signed($urandom_range(4194304)) - 32'sd2097152);
                endcase
            end
            if (ph == 0 || ph == 6) cfg_vals[7] = 32'd16777216;
            write_regs(cfg_vals);
            send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 80 : 26) : 0;
            recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 2) ? 80 : 26) : 0;
            for (int i = 0; i < 153; i++) begin
                if (ph == 0 && i == 20) hold_req = HOLD_LEN;
                if (ph == 6 && i == 70) begin
                    stop_sending();
                    while (gen_model.expected_q.size() != 0) @(posedge i_clk);
                end
                send_step(random_step());
            end
            stop_sending();
        end

        recv_stall_pct = 0;
        wait_drained();
        if (gen_model.errors == 0 && gen_model.expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
